>>> sv/wsfd_pkg.sv
package wsfd_pkg;

   // length counter width, 16 to 64
   localparam int LENGTH_BITS = 64;

   // result kinds
   localparam logic [1:0] KIND_PAYLOAD = 2'd0;
   localparam logic [1:0] KIND_EMPTY   = 2'd1;
   localparam logic [1:0] KIND_CLOSE   = 2'd2;

   // opcodes with special handling
   localparam logic [3:0] OP_CLOSE = 4'h8;
   localparam logic [3:0] OP_PING  = 4'h9;
   localparam logic [3:0] OP_PONG  = 4'hA;

   // short length codes that select an extended length
   localparam logic [6:0] LEN7_EXT16 = 7'd126;
   localparam logic [6:0] LEN7_EXT64 = 7'd127;
   localparam logic [3:0] EXT16_BYTES = 4'd2;
   localparam logic [3:0] EXT64_BYTES = 4'd8;

   // parser phases, one-hot
   typedef enum logic [4:0] {
      PH_HDR0 = 5'b00001,
      PH_HDR1 = 5'b00010,
      PH_EXT  = 5'b00100,
      PH_KEY  = 5'b01000,
      PH_PAY  = 5'b10000
   } phase_type;

   // one result item
   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] data;
      logic [3:0] opcode;
      logic       last;
   } result_type;

endpackage

>>> sv/wsfd_parser.sv
module wsfd_parser (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [7:0]             req_in_byte,
   input  logic                   out_ready,
   output logic                   res_valid,
   output wsfd_pkg::result_type   res_item
);

   localparam int LB = wsfd_pkg::LENGTH_BITS;

   logic                  in_valid_ff, in_valid_in;
   logic [7:0]            in_byte_ff, in_byte_in;
   wsfd_pkg::phase_type   phase_ff, phase_in;
   logic [3:0]            opcode_ff, opcode_in;
   logic                  masked_ff, masked_in;
   logic [3:0]            ext_left_ff, ext_left_in;
   logic [LB-1:0]         rem_ff, rem_in;
   logic [31:0]           key_ff, key_in;
   logic [1:0]            key_pos_ff, key_pos_in;
   logic                  closed_ff, closed_in;

   logic                  fire;
   logic                  ctrl_skip;
   logic                  len_complete;
   logic                  hdr_done;
   logic [LB-1:0]         rem_dec;
   logic [LB-1:0]         rem_shift;
   logic                  rem_sat;
   logic [7:0]            key_byte;
   logic [3:0]            ext_dec;

   // input register
   assign fire      = in_valid_ff && out_ready;
   assign req_stall = in_valid_ff && !out_ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_byte_in  = in_byte_ff;
      if (req_valid && !req_stall) begin
         in_valid_in = 1'b1;
         in_byte_in  = req_in_byte;
      end else if (fire) begin
         in_valid_in = 1'b0;
      end
   end

   // helpers for the length and key datapath
   assign ctrl_skip = (opcode_ff == wsfd_pkg::OP_PING) || (opcode_ff == wsfd_pkg::OP_PONG);
   assign rem_dec   = rem_ff - LB'(1);
   assign rem_shift = {rem_ff[LB-9:0], in_byte_ff};
   assign rem_sat   = |rem_ff[LB-1:LB-8];
   assign ext_dec   = ext_left_ff - 4'd1;

   always_comb begin
      case (key_pos_ff)
         2'd0:    key_byte = key_ff[31:24];
         2'd1:    key_byte = key_ff[23:16];
         2'd2:    key_byte = key_ff[15:8];
         default: key_byte = key_ff[7:0];
      endcase
   end

   // frame decode, one byte per fire
   always_comb begin
      phase_in     = phase_ff;
      opcode_in    = opcode_ff;
      masked_in    = masked_ff;
      ext_left_in  = ext_left_ff;
      rem_in       = rem_ff;
      key_in       = key_ff;
      key_pos_in   = key_pos_ff;
      closed_in    = closed_ff;
      len_complete = 1'b0;
      hdr_done     = 1'b0;
      res_valid    = 1'b0;
      res_item     = '{kind: wsfd_pkg::KIND_PAYLOAD, data: 8'd0, opcode: opcode_ff, last: 1'b1};

      if (fire && !closed_ff) begin
         case (phase_ff)
            wsfd_pkg::PH_HDR0: begin
               opcode_in = in_byte_ff[3:0];
               phase_in  = wsfd_pkg::PH_HDR1;
            end
            wsfd_pkg::PH_HDR1: begin
               masked_in = in_byte_ff[7];
               if (opcode_ff == wsfd_pkg::OP_CLOSE) begin
                  closed_in     = 1'b1;
                  phase_in      = wsfd_pkg::PH_HDR0;
                  res_valid     = 1'b1;
                  res_item.kind = wsfd_pkg::KIND_CLOSE;
               end else begin
                  rem_in = '0;
                  if (in_byte_ff[6:0] == wsfd_pkg::LEN7_EXT16) begin
                     ext_left_in = wsfd_pkg::EXT16_BYTES;
                     phase_in    = wsfd_pkg::PH_EXT;
                  end else if (in_byte_ff[6:0] == wsfd_pkg::LEN7_EXT64) begin
                     ext_left_in = wsfd_pkg::EXT64_BYTES;
                     phase_in    = wsfd_pkg::PH_EXT;
                  end else begin
                     rem_in       = LB'(in_byte_ff[6:0]);
                     len_complete = 1'b1;
                  end
               end
            end
            wsfd_pkg::PH_EXT: begin
               // saturate when another byte would overflow
               rem_in       = rem_sat ? '1 : rem_shift;
               ext_left_in  = ext_dec;
               len_complete = (ext_dec == 4'd0);
            end
            wsfd_pkg::PH_KEY: begin
               key_in     = {key_ff[23:0], in_byte_ff};
               key_pos_in = key_pos_ff + 2'd1;
               hdr_done   = (key_pos_ff == 2'd3);
            end
            wsfd_pkg::PH_PAY: begin
               key_pos_in = key_pos_ff + 2'd1;
               rem_in     = rem_dec;
               if (rem_dec == '0) begin
                  phase_in = wsfd_pkg::PH_HDR0;
               end
               res_valid     = !ctrl_skip;
               res_item.kind = wsfd_pkg::KIND_PAYLOAD;
               res_item.data = masked_ff ? (in_byte_ff ^ key_byte) : in_byte_ff;
               res_item.last = (rem_dec == '0);
            end
            default: begin
               phase_in = wsfd_pkg::PH_HDR0;
            end
         endcase

         // length known: collect the key or finish the header
         if (len_complete) begin
            if (masked_in) begin
               phase_in   = wsfd_pkg::PH_KEY;
               key_pos_in = 2'd0;
               key_in     = '0;
            end else begin
               hdr_done = 1'b1;
            end
         end

         // header complete: empty frame or payload
         if (hdr_done) begin
            key_pos_in = 2'd0;
            if (rem_in == '0) begin
               phase_in      = wsfd_pkg::PH_HDR0;
               res_valid     = !ctrl_skip;
               res_item.kind = wsfd_pkg::KIND_EMPTY;
               res_item.data = 8'd0;
               res_item.last = 1'b1;
            end else begin
               phase_in = wsfd_pkg::PH_PAY;
            end
         end
      end
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         phase_ff    <= wsfd_pkg::PH_HDR0;
         opcode_ff   <= 4'd0;
         masked_ff   <= 1'b0;
         ext_left_ff <= 4'd0;
         rem_ff      <= '0;
         key_ff      <= '0;
         key_pos_ff  <= 2'd0;
         closed_ff   <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
         phase_ff    <= phase_in;
         opcode_ff   <= opcode_in;
         masked_ff   <= masked_in;
         ext_left_ff <= ext_left_in;
         rem_ff      <= rem_in;
         key_ff      <= key_in;
         key_pos_ff  <= key_pos_in;
         closed_ff   <= closed_in;
      end
   end

   always_ff @(posedge clock) begin
      in_byte_ff <= in_byte_in;
   end

`ifndef NO_ASSERTIONS
   // once closed, stays closed until reset
   a_closed_sticky: assert property (@(posedge clock) disable iff (reset)
      closed_ff |=> closed_ff)
      else $error("closed flag dropped");

   // no result after the connection is closed
   a_no_result_closed: assert property (@(posedge clock) disable iff (reset)
      closed_ff |-> !res_valid)
      else $error("result after close");

   // a result only leaves with a consumed byte
   a_result_needs_fire: assert property (@(posedge clock) disable iff (reset)
      res_valid |-> fire)
      else $error("result without input byte");

   // payload phase always has bytes left
   a_payload_nonzero: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == wsfd_pkg::PH_PAY) |-> (rem_ff != '0))
      else $error("payload phase with zero length");
`endif

endmodule

>>> sv/wsfd_out_reg.sv
module wsfd_out_reg (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   res_valid,
   input  wsfd_pkg::result_type   res_item,
   output logic                   out_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output wsfd_pkg::result_type   rsp_item
);

   logic                   valid_ff, valid_in;
   wsfd_pkg::result_type   item_ff, item_in;

   // result register, refilled whenever it is empty or being taken
   assign out_ready = !valid_ff || !rsp_stall;

   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (out_ready) begin
         valid_in = res_valid;
         item_in  = res_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_item  = item_ff;

endmodule

>>> sv/websocket_frame_decoder_core.sv
// Frame decoder for a websocket byte stream after the opening handshake. One byte
// is taken per clock, sustained while rsp_stall is low; an accepted byte passes
// the input register, then the result register; the single decode stage between
// them sets that rate. Each byte gives at most one item: an unmasked payload byte
// (last_of_frame on the final one), an empty-frame marker for a zero-length data
// frame, or a close marker, after which all input is consumed and dropped until
// reset. Ping and pong frames are skipped by their length without output. FIN and
// RSV bits are ignored and fragments are passed on as separate frames.
module websocket_frame_decoder_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_in_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_out_kind,
   output logic [7:0]  rsp_out_byte,
   output logic [3:0]  rsp_frame_opcode,
   output logic        rsp_last_of_frame
);

   logic                   out_ready;
   logic                   res_valid;
   wsfd_pkg::result_type   res_item;
   wsfd_pkg::result_type   rsp_item;

   // header parse, unmasking and length tracking
   wsfd_parser u_parser (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_in_byte (req_in_byte),
      .out_ready   (out_ready),
      .res_valid   (res_valid),
      .res_item    (res_item)
   );

   // result register
   wsfd_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .res_valid (res_valid),
      .res_item  (res_item),
      .out_ready (out_ready),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item)
   );

   assign rsp_out_kind      = rsp_item.kind;
   assign rsp_out_byte      = rsp_item.data;
   assign rsp_frame_opcode  = rsp_item.opcode;
   assign rsp_last_of_frame = rsp_item.last;

endmodule
